[sv/hcbp_pkg.sv]
// hcbp_pkg: shared types and codes for the huffman code bit packer
// transfer payload structs for the input and result channels; no dependencies

package hcbp_pkg;

  // fixed field widths
  localparam int CODE_BITS_W = 32;
  localparam int CODE_LEN_W  = 6;

  // request codes
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_ENCODE = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;

  // result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_CODE = 1'b1;

  // meaningful bit count of a full byte
  localparam logic [3:0] FULL_BYTE_BITS = 4'd8;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [7:0]             symbol;
    logic [CODE_BITS_W-1:0] code_bits;
    logic [CODE_LEN_W-1:0]  code_len;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       status;
    logic [3:0] meaningful_bits;
    logic       last_of_run;
  } out_item_t;

endpackage

[sv/hcbp_ram.sv]
// hcbp_ram: generic synchronous ram, one write and one read port, registered read
// standalone; no package needed

module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  // read data holds until the next read
  assign rdata = rdata_r;

endmodule

[sv/huffman_code_bit_packer_unit.sv]
// huffman_code_bit_packer_unit: table-driven huffman encoder with byte packing
// uses hcbp_pkg for payload types and codes, hcbp_ram for the code table

// Usage: requests enter on in_* (load a code, encode a symbol, flush the
// final partial byte) and bytes leave on out_*, first code bit in bit 7.
// One request is taken per clock cycle while in_stall is low. Loads, unknown
// request types and encodes of a coded symbol that complete no byte give no
// transfer on out_*; an encode of an uncoded symbol and a flush each give one
// result, and an encode that completes n bytes gives n results (up to 4 for
// 32-bit codes) and holds the output until all have left, so a stream of long
// codes runs at the output's one result per cycle while out_stall is low. The
// first result of a request passes the code table read, which the pack stage
// uses, and then the result buffer that the pack stage fills. The code table
// sits in a synchronous ram with a registered read; a row of per-entry written
// flags, cleared at reset, makes unwritten entries read as uncoded, so there
// is no clearing pass and requests are taken straight out of reset. A load is
// visible to an encode in the very next cycle. Codes longer than MAX_CODE_LEN
// (or 32) are cut to that length and keep their low bits; symbols at or above
// ALPHABET_SIZE are never coded.

module huffman_code_bit_packer_unit
  import hcbp_pkg::*;
#(
  parameter int ALPHABET_SIZE = 256,
  parameter int MAX_CODE_LEN  = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // stored code width is the length cap
  localparam int CAP   = (MAX_CODE_LEN < CODE_BITS_W) ? MAX_CODE_LEN : CODE_BITS_W;
  localparam int LW    = $clog2(CAP + 1);      // stored length width
  localparam int AW    = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int ACCW  = CAP + 7;              // pending bits plus one code
  localparam int TW    = $clog2(ACCW + 1);     // bit total width
  localparam int NB    = ACCW / 8;             // most bytes from one encode
  localparam int CW    = $clog2(NB + 1);       // result count width

  // ---------------------------------------------------------------------------
  // issue stage: table write on load, table read on encode
  // ---------------------------------------------------------------------------
  logic                 in_fire;
  logic                 in_range;
  logic [AW-1:0]        tbl_addr;
  logic [LW-1:0]        len_sat;
  logic [CAP-1:0]       code_mask;
  logic                 tbl_we;
  logic                 tbl_re;
  logic [CAP+LW-1:0]    tbl_wdata;
  logic [CAP+LW-1:0]    tbl_rdata;
  logic [ALPHABET_SIZE-1:0] code_vld_r, code_vld_nxt;

  assign in_fire  = in_valid && !in_stall;
  assign in_range = ({1'b0, in_data.symbol} < 9'(ALPHABET_SIZE));
  assign tbl_addr = in_data.symbol[AW-1:0];

  // saturate the length and drop code bits above it
  always_comb begin
    len_sat = (in_data.code_len > 6'(CAP)) ? LW'(CAP) : LW'(in_data.code_len);
    for (int i = 0; i < CAP; i++) begin
      code_mask[i] = (i < int'(len_sat));
    end
  end

  assign tbl_wdata = {len_sat, in_data.code_bits[CAP-1:0] & code_mask};
  assign tbl_we    = in_fire && (in_data.req_type == REQ_LOAD) && in_range;
  assign tbl_re    = in_fire && (in_data.req_type == REQ_ENCODE) && in_range;

  hcbp_ram #(
    .WIDTH (CAP + LW),
    .DEPTH (ALPHABET_SIZE)
  ) u_code_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_addr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_addr),
    .rdata (tbl_rdata)
  );

  // written flags stand in for a reset of the table
  always_comb begin
    code_vld_nxt = code_vld_r;
    if (tbl_we) begin
      code_vld_nxt[tbl_addr] = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // pack stage: request meets its table read data here and waits while the result buffer is busy
  // ---------------------------------------------------------------------------
  logic       s1_v_r, s1_v_nxt;
  logic [1:0] s1_req_r;
  logic       s1_hit_r;           // in range and entry written
  logic       s1_adv;

  logic [6:0] pend_bits_r, pend_bits_nxt;
  logic [2:0] pend_cnt_r, pend_cnt_nxt;

  logic [LW-1:0]   rd_len;
  logic [CAP-1:0]  rd_code;
  logic            coded;
  logic [ACCW-1:0] acc;
  logic [ACCW-1:0] acc_al;
  logic [TW-1:0]   total;
  logic [CW-1:0]   enc_cnt;
  logic [2:0]      rem_bits;
  logic [6:0]      rem_mask;
  logic [7:0]      flush_byte;

  // result buffer fill for the request in the pack stage
  logic [CW-1:0] res_cnt;
  logic [7:0]    res_byte [NB];
  logic          res_bv;
  logic          res_st;
  logic [3:0]    res_mb;

  assign rd_len  = tbl_rdata[CAP+LW-1:CAP];
  assign rd_code = tbl_rdata[CAP-1:0];
  assign coded   = s1_hit_r && (rd_len != '0);

  // append the code below the pending bits, then left-align for byte slicing
  assign acc      = (ACCW'(pend_bits_r) << rd_len) | ACCW'(rd_code);
  assign total    = TW'(pend_cnt_r) + TW'(rd_len);
  assign enc_cnt  = CW'(total >> 3);
  assign acc_al   = acc << (TW'(ACCW) - total);
  assign rem_bits = total[2:0];
  assign rem_mask = 7'((8'd1 << rem_bits) - 8'd1);

  // pad the partial byte with zeros on the right
  assign flush_byte = 8'({1'b0, pend_bits_r} << (4'd8 - {1'b0, pend_cnt_r}));

  always_comb begin
    res_cnt = '0;
    res_bv  = 1'b1;
    res_st  = STATUS_OK;
    res_mb  = FULL_BYTE_BITS;
    for (int k = 0; k < NB; k++) begin
      res_byte[k] = acc_al[ACCW-1-8*k -: 8];
    end
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    case (s1_req_r)
      REQ_ENCODE: begin
        if (coded) begin
          res_cnt       = enc_cnt;
          pend_bits_nxt = acc[6:0] & rem_mask;
          pend_cnt_nxt  = rem_bits;
        end else begin
          // uncoded symbol: error result, pending bits untouched
          res_cnt     = CW'(1);
          res_bv      = 1'b0;
          res_st      = STATUS_NO_CODE;
          res_byte[0] = 8'd0;
        end
      end
      REQ_FLUSH: begin
        res_cnt       = CW'(1);
        pend_bits_nxt = '0;
        pend_cnt_nxt  = '0;
        if (pend_cnt_r == '0) begin
          res_bv      = 1'b0;
          res_byte[0] = 8'd0;
        end else begin
          res_byte[0] = flush_byte;
          res_mb      = {1'b0, pend_cnt_r};
        end
      end
      default: begin
        res_cnt = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // result buffer: drives the output, one result per transfer
  // ---------------------------------------------------------------------------
  logic          s2_v_r, s2_v_nxt;
  logic [CW-1:0] s2_rem_r, s2_rem_nxt;
  logic [7:0]    s2_byte_r [NB];
  logic [7:0]    s2_byte_nxt [NB];
  logic          s2_bv_r, s2_bv_nxt;
  logic          s2_st_r, s2_st_nxt;
  logic [3:0]    s2_mb_r, s2_mb_nxt;
  logic          out_fire;
  logic          s2_free;

  assign out_fire = out_valid && !out_stall;
  assign s2_free  = !s2_v_r || (out_fire && (s2_rem_r == CW'(1)));

  // a request with no result leaves without waiting for the buffer
  assign s1_adv   = s1_v_r && ((res_cnt == '0) || s2_free);
  assign in_stall = s1_v_r && !s1_adv;

  // only encodes and flushes go on to the pack stage
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_fire) begin
      s1_v_nxt = (in_data.req_type == REQ_ENCODE) || (in_data.req_type == REQ_FLUSH);
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_comb begin
    s2_v_nxt    = s2_v_r;
    s2_rem_nxt  = s2_rem_r;
    s2_byte_nxt = s2_byte_r;
    s2_bv_nxt   = s2_bv_r;
    s2_st_nxt   = s2_st_r;
    s2_mb_nxt   = s2_mb_r;
    if (s1_adv && (res_cnt != '0)) begin
      s2_v_nxt    = 1'b1;
      s2_rem_nxt  = res_cnt;
      s2_byte_nxt = res_byte;
      s2_bv_nxt   = res_bv;
      s2_st_nxt   = res_st;
      s2_mb_nxt   = res_mb;
    end else if (out_fire) begin
      // shift the next byte into the head slot
      s2_v_nxt   = (s2_rem_r != CW'(1));
      s2_rem_nxt = s2_rem_r - CW'(1);
      for (int k = 0; k < NB - 1; k++) begin
        s2_byte_nxt[k] = s2_byte_r[k+1];
      end
      s2_byte_nxt[NB-1] = 8'd0;
    end
  end

  assign out_valid                = s2_v_r;
  assign out_data.out_byte        = s2_byte_r[0];
  assign out_data.byte_valid      = s2_bv_r;
  assign out_data.status          = s2_st_r;
  assign out_data.meaningful_bits = s2_mb_r;
  assign out_data.last_of_run     = (s2_rem_r == CW'(1));

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_vld_r  <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s2_rem_r    <= '0;
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else begin
      code_vld_r <= code_vld_nxt;
      s1_v_r     <= s1_v_nxt;
      s2_v_r     <= s2_v_nxt;
      s2_rem_r   <= s2_rem_nxt;
      if (s1_adv) begin
        pend_bits_r <= pend_bits_nxt;
        pend_cnt_r  <= pend_cnt_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r <= in_data.req_type;
      s1_hit_r <= in_range && code_vld_r[tbl_addr];
    end
    s2_byte_r <= s2_byte_nxt;
    s2_bv_r   <= s2_bv_nxt;
    s2_st_r   <= s2_st_nxt;
    s2_mb_r   <= s2_mb_nxt;
  end

`ifndef SYNTHESIS
  // the result buffer always holds between one and the maximum count
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> ((s2_rem_r != '0) && (s2_rem_r <= CW'(NB))))
    else $error("result buffer count out of range");

  // an error result carries no byte and ends its request
  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == STATUS_NO_CODE)) |->
      (!out_data.byte_valid && out_data.last_of_run && (out_data.out_byte == 8'd0)))
    else $error("error result malformed");

  // a flush leaves nothing pending
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_req_r == REQ_FLUSH)) |=> (pend_cnt_r == '0) && (pend_bits_r == '0))
    else $error("pending bits survive a flush");

  // a request that waits in the pack stage keeps its table read data
  a_hold_read: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_adv) |=> (s1_v_r && $stable(tbl_rdata) && $stable(s1_req_r)))
    else $error("pack stage lost its request while stalled");

  // pending bits above the pending count stay zero
  a_pend_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_bits_r & ~7'((8'd1 << pend_cnt_r) - 8'd1)) == 7'd0)
    else $error("stray pending bits");
`endif

endmodule
